>>> hw/rtl/dynamic_palette_indexer_defines.svh
// Assertion macros shared by the palette indexer checker.
`ifndef DYNAMIC_PALETTE_INDEXER_DEFINES_SVH
`define DYNAMIC_PALETTE_INDEXER_DEFINES_SVH

// Generic clocked property, masked while reset is asserted.
`define DPX_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// A stalled beat keeps valid high and the given signal unchanged.
`define DPX_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		(vld && !rdy) |=> (vld && $stable(sig))) else $error(msg);

`endif

>>> hw/rtl/dpx_pkg.sv
// Shared types and constants for the dynamic palette indexer.
`timescale 1ns / 1ps

package dpx_pkg;

	localparam int CH_W      = 8;   // one color channel
	localparam int COLOR_W   = 24;  // packed {blue, green, red}
	localparam int IDX_OUT_W = 8;   // width of the palette_index port
	localparam int GRP_SIZE  = 16;  // palette entries per compare group
	localparam int GRP_SEL_W = 4;   // index within a group

	typedef logic [COLOR_W-1:0] color_t;

	// Palette write request, issued when a new color is stored
	typedef struct packed {
		logic   en;
		color_t color;
	} cam_wr_t;

	// Lookup outcome flags for one pixel
	typedef struct packed {
		logic is_new;
		logic overflow;
	} dec_t;

endpackage

>>> hw/rtl/dpx_cam.sv
// Palette storage in flops with a parallel compare and per-group priority encode.
`timescale 1ns / 1ps

module dpx_cam #(
	parameter int PALETTE_ENTRIES = 256,
	localparam int IDX_W   = $clog2(PALETTE_ENTRIES),
	localparam int CNT_W   = $clog2(PALETTE_ENTRIES + 1),
	localparam int NUM_GRP = (PALETTE_ENTRIES + dpx_pkg::GRP_SIZE - 1) / dpx_pkg::GRP_SIZE
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dpx_pkg::color_t       lookup_color,
	input  logic                  load_s2,
	input  dpx_pkg::cam_wr_t      wr,
	output logic [CNT_W-1:0]      count_q,
	output logic [NUM_GRP-1:0]    grp_hit_s2,
	output logic [NUM_GRP-1:0][dpx_pkg::GRP_SEL_W-1:0] grp_sel_s2
);

	dpx_pkg::color_t palette_q [PALETTE_ENTRIES];
	logic [NUM_GRP*dpx_pkg::GRP_SIZE-1:0] match;
	logic [NUM_GRP-1:0] grp_hit_d;
	logic [NUM_GRP-1:0][dpx_pkg::GRP_SEL_W-1:0] grp_sel_d;

	// Compare the lookup color against every filled entry
	always_comb begin
		match = '0;
		for (int i = 0; i < PALETTE_ENTRIES; i++) begin
			match[i] = (CNT_W'(i) < count_q) && (palette_q[i] == lookup_color);
		end
	end

	// Lowest matching entry inside each group of sixteen
	always_comb begin
		for (int g = 0; g < NUM_GRP; g++) begin
			grp_hit_d[g] = |match[g*dpx_pkg::GRP_SIZE +: dpx_pkg::GRP_SIZE];
			grp_sel_d[g] = '0;
			for (int k = dpx_pkg::GRP_SIZE - 1; k >= 0; k--) begin
				if (match[g*dpx_pkg::GRP_SIZE + k]) begin
					grp_sel_d[g] = dpx_pkg::GRP_SEL_W'(k);
				end
			end
		end
	end

	// Group results move with the pixel into stage two
	always_ff @(posedge clk) begin
		if (load_s2) begin
			grp_hit_s2 <= grp_hit_d;
			grp_sel_s2 <= grp_sel_d;
		end
	end

	// New colors fill the next free slot; contents undefined until written
	always_ff @(posedge clk) begin
		if (wr.en) begin
			palette_q[count_q[IDX_W-1:0]] <= wr.color;
		end
	end

	// Fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (wr.en) begin
			count_q <= count_q + 1'b1;
		end
	end

endmodule

>>> hw/rtl/dpx_resolve.sv
// Final index selection: group priority, bypass of the last insert, full check.
`timescale 1ns / 1ps

module dpx_resolve #(
	parameter int PALETTE_ENTRIES = 256,
	localparam int IDX_W   = $clog2(PALETTE_ENTRIES),
	localparam int CNT_W   = $clog2(PALETTE_ENTRIES + 1),
	localparam int NUM_GRP = (PALETTE_ENTRIES + dpx_pkg::GRP_SIZE - 1) / dpx_pkg::GRP_SIZE
) (
	input  logic [NUM_GRP-1:0]    grp_hit,
	input  logic [NUM_GRP-1:0][dpx_pkg::GRP_SEL_W-1:0] grp_sel,
	input  logic [CNT_W-1:0]      count,
	input  dpx_pkg::color_t       color,
	input  logic                  fwd_vld,
	input  dpx_pkg::color_t       fwd_color,
	input  logic [IDX_W-1:0]      fwd_idx,
	output logic [IDX_W-1:0]      idx,
	output dpx_pkg::dec_t         dec
);

	localparam int GRP_IDX_W = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
	localparam int FULL_W    = GRP_IDX_W + dpx_pkg::GRP_SEL_W;

	logic              tab_hit;
	logic [FULL_W-1:0] tab_idx;
	logic              fwd_hit;
	logic              full;

	// Lowest matching group wins
	always_comb begin
		tab_hit = 1'b0;
		tab_idx = '0;
		for (int g = NUM_GRP - 1; g >= 0; g--) begin
			if (grp_hit[g]) begin
				tab_hit = 1'b1;
				tab_idx = {GRP_IDX_W'(g), grp_sel[g]};
			end
		end
	end

	// The color stored as this pixel entered stage two was not yet in the compare
	assign fwd_hit = fwd_vld && (fwd_color == color);
	assign full    = (count == CNT_W'(PALETTE_ENTRIES));

	always_comb begin
		if (fwd_hit) begin
			idx = fwd_idx;
		end else if (tab_hit) begin
			idx = tab_idx[IDX_W-1:0];
		end else if (full) begin
			idx = '0;
		end else begin
			idx = count[IDX_W-1:0];
		end
		dec.is_new   = !fwd_hit && !tab_hit && !full;
		dec.overflow = !fwd_hit && !tab_hit && full;
	end

endmodule

>>> hw/rtl/dpx_addr.sv
// Column-major store address: column times height, plus row.
`timescale 1ns / 1ps

module dpx_addr #(
	parameter int MAX_DIMENSION = 4096,
	localparam int DIM_W  = $clog2(MAX_DIMENSION),
	localparam int ADDR_W = 2 * DIM_W
) (
	input  logic              clk,
	input  logic              load,
	input  logic [DIM_W-1:0]  column,
	input  logic [DIM_W:0]    height,
	input  logic [DIM_W-1:0]  row_s2,
	output logic [ADDR_W-1:0] address
);

	logic [2*DIM_W:0]  prod_full;
	logic [ADDR_W-1:0] prod_s2;

	// Multiply in stage one, wraps to the address width
	assign prod_full = column * height;

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s2 <= prod_full[ADDR_W-1:0];
		end
	end

	// Add the row in stage two
	assign address = prod_s2 + ADDR_W'(row_s2);

endmodule

>>> hw/rtl/dynamic_palette_indexer.sv
// Dynamic palette indexer: pixel color to palette index plus store address.
// Throughput: one pixel per cycle sustained; stalls only on output backpressure.
// Pipeline: input register, compare register, result register; the palette compare
// against all entries and the column by height multiply each take one stage.
// Reset: palette empty, image height 1; no clearing pass, entries beyond the fill count are ignored.
`timescale 1ns / 1ps

module dynamic_palette_indexer #(
	parameter int PALETTE_ENTRIES = 256,
	parameter int MAX_DIMENSION   = 4096,
	localparam int DIM_W  = $clog2(MAX_DIMENSION),
	localparam int ADDR_W = 2 * DIM_W
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration write
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [DIM_W:0]             cfg_data,
	// pixel input
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [dpx_pkg::CH_W-1:0]   red,
	input  logic [dpx_pkg::CH_W-1:0]   green,
	input  logic [dpx_pkg::CH_W-1:0]   blue,
	input  logic [DIM_W-1:0]           column,
	input  logic [DIM_W-1:0]           row,
	// result output
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [dpx_pkg::IDX_OUT_W-1:0] palette_index,
	output logic                       new_entry,
	output logic                       palette_overflow,
	output logic [ADDR_W-1:0]          store_address
);

	localparam int IDX_W   = $clog2(PALETTE_ENTRIES);
	localparam int CNT_W   = $clog2(PALETTE_ENTRIES + 1);
	localparam int NUM_GRP = (PALETTE_ENTRIES + dpx_pkg::GRP_SIZE - 1) / dpx_pkg::GRP_SIZE;
	localparam int PAD_W   = (IDX_W > dpx_pkg::IDX_OUT_W) ? IDX_W : dpx_pkg::IDX_OUT_W;

	// pipeline control
	logic out_adv, s2_adv, s2_fire, s1_adv, load_s2;
	logic valid_s1, valid_s2, out_valid_q;

	// payload
	logic [DIM_W:0]       height_q;
	dpx_pkg::color_t      color_s1, color_s2;
	logic [DIM_W-1:0]     column_s1, row_s1, row_s2;
	logic                 fwd_vld_s2;
	dpx_pkg::color_t      fwd_color_s2;
	logic [IDX_W-1:0]     fwd_idx_s2;

	logic [dpx_pkg::IDX_OUT_W-1:0] index_q;
	logic                 new_q, ovf_q;
	logic [ADDR_W-1:0]    addr_q;

	// stage two results
	logic [CNT_W-1:0]     count;
	logic [NUM_GRP-1:0]   grp_hit_s2;
	logic [NUM_GRP-1:0][dpx_pkg::GRP_SEL_W-1:0] grp_sel_s2;
	logic [IDX_W-1:0]     res_idx;
	logic [PAD_W-1:0]     idx_pad;
	dpx_pkg::dec_t        dec;
	dpx_pkg::cam_wr_t     wr;
	logic [ADDR_W-1:0]    address;

	// Handshake chain: each stage moves when the one after it has room
	assign out_adv  = !out_valid_q || out_ready;
	assign s2_adv   = !valid_s2 || out_adv;
	assign s2_fire  = valid_s2 && out_adv;
	assign s1_adv   = !valid_s1 || s2_adv;
	assign load_s2  = valid_s1 && s2_adv;
	assign in_ready = s1_adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			fwd_vld_s2  <= 1'b0;
			height_q    <= (DIM_W+1)'(1);
		end else begin
			if (s1_adv) begin
				valid_s1 <= in_valid;
			end
			if (s2_adv) begin
				valid_s2 <= valid_s1;
			end
			if (out_adv) begin
				out_valid_q <= valid_s2;
			end
			if (load_s2) begin
				fwd_vld_s2 <= s2_fire && dec.is_new;
			end
			if (cfg_valid) begin
				height_q <= cfg_data;
			end
		end
	end

	// Stage one: input register
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			color_s1  <= {blue, green, red};
			column_s1 <= column;
			row_s1    <= row;
		end
	end

	// Stage two: pixel plus the insert made as it entered, for bypass
	always_ff @(posedge clk) begin
		if (load_s2) begin
			color_s2     <= color_s1;
			row_s2       <= row_s1;
			fwd_color_s2 <= color_s2;
			fwd_idx_s2   <= res_idx;
		end
	end

	dpx_cam #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_cam (
		.clk          (clk),
		.arst_n       (arst_n),
		.lookup_color (color_s1),
		.load_s2      (load_s2),
		.wr           (wr),
		.count_q      (count),
		.grp_hit_s2   (grp_hit_s2),
		.grp_sel_s2   (grp_sel_s2)
	);

	dpx_resolve #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_resolve (
		.grp_hit   (grp_hit_s2),
		.grp_sel   (grp_sel_s2),
		.count     (count),
		.color     (color_s2),
		.fwd_vld   (fwd_vld_s2),
		.fwd_color (fwd_color_s2),
		.fwd_idx   (fwd_idx_s2),
		.idx       (res_idx),
		.dec       (dec)
	);

	dpx_addr #(
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_addr (
		.clk     (clk),
		.load    (load_s2),
		.column  (column_s1),
		.height  (height_q),
		.row_s2  (row_s2),
		.address (address)
	);

	// Store the color when the beat leaves stage two as a new entry
	assign wr.en    = s2_fire && dec.is_new;
	assign wr.color = color_s2;

	// Result register
	assign idx_pad = PAD_W'(res_idx);

	always_ff @(posedge clk) begin
		if (out_adv) begin
			index_q <= idx_pad[dpx_pkg::IDX_OUT_W-1:0];
			new_q   <= dec.is_new;
			ovf_q   <= dec.overflow;
			addr_q  <= address;
		end
	end

	assign out_valid        = out_valid_q;
	assign palette_index    = index_q;
	assign new_entry        = new_q;
	assign palette_overflow = ovf_q;
	assign store_address    = addr_q;

endmodule

>>> hw/rtl/dpx_checker.sv
// Port-level checks on the palette indexer result channel, bound to the top level.
`timescale 1ns / 1ps
`include "dynamic_palette_indexer_defines.svh"

module dpx_checker #(
	parameter int MAX_DIMENSION = 4096,
	localparam int ADDR_W = 2 * $clog2(MAX_DIMENSION)
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [dpx_pkg::IDX_OUT_W-1:0] palette_index,
	input logic                          new_entry,
	input logic                          palette_overflow,
	input logic [ADDR_W-1:0]             store_address
);

	// stalled result beat holds
	`DPX_ASSERT_HOLD(a_hold_index, out_valid, out_ready, palette_index, "index changed while stalled")
	`DPX_ASSERT_HOLD(a_hold_addr, out_valid, out_ready, store_address, "address changed while stalled")

	// a color is never flagged both new and overflowing
	`DPX_ASSERT(a_flags_excl, out_valid |-> !(new_entry && palette_overflow), "new and overflow together")

	// overflow maps to index zero
	`DPX_ASSERT(a_ovf_zero, (out_valid && palette_overflow) |-> (palette_index == '0), "overflow index not zero")

	// once full the palette stays full: no new entry right after an overflow
	`DPX_ASSERT(a_full_sticky, (out_valid && out_ready && palette_overflow) |=> !(out_valid && new_entry), "new entry after overflow")

endmodule

bind dynamic_palette_indexer dpx_checker #(
	.MAX_DIMENSION(MAX_DIMENSION)
) u_dpx_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.palette_index    (palette_index),
	.new_entry        (new_entry),
	.palette_overflow (palette_overflow),
	.store_address    (store_address)
);

>>> tb/dynamic_palette_indexer_checker.sv
// Scoreboard for the palette indexer: watches all channels, predicts each pixel and compares.
`timescale 1ns / 1ps

module dynamic_palette_indexer_checker #(
	parameter int ENTRIES = 256,
	parameter int DIM_W   = 12,
	parameter int ADDR_W  = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [DIM_W:0]                  cfg_data,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [dpx_pkg::CH_W-1:0]        red,
	input  logic [dpx_pkg::CH_W-1:0]        green,
	input  logic [dpx_pkg::CH_W-1:0]        blue,
	input  logic [DIM_W-1:0]                column,
	input  logic [DIM_W-1:0]                row,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [dpx_pkg::IDX_OUT_W-1:0]   palette_index,
	input  logic                            new_entry,
	input  logic                            palette_overflow,
	input  logic [ADDR_W-1:0]               store_address,
	output int                              mismatches,
	output int                              pending,
	output int                              results_checked,
	output int                              new_colors,
	output int                              overflows
);

	typedef struct packed {
		logic [dpx_pkg::IDX_OUT_W-1:0] index;
		logic                          is_new;
		logic                          overflow;
		logic [ADDR_W-1:0]             addr;
	} pixel_result_t;

	// predictor state: stored colors, fill level, image height
	dpx_pkg::color_t palette_mirror [ENTRIES];
	int unsigned     fill_level;
	logic [DIM_W:0]  height_mirror;
	pixel_result_t   expected_q [$];

	// Look the color up, store it if new and there is room, and form the address.
	function automatic pixel_result_t index_pixel(input dpx_pkg::color_t c,
			input logic [DIM_W-1:0] px_col, input logic [DIM_W-1:0] px_row);
		pixel_result_t res;
		int unsigned   slot;
		bit            found;
		logic [31:0]   addr;
		res   = '0;
		slot  = 0;
		found = 1'b0;
		// lowest matching entry among the filled ones wins
		for (int i = 0; i < fill_level; i++) begin
			if (!found && palette_mirror[i] == c) begin
				slot  = i;
				found = 1'b1;
			end
		end
		if (found) begin
			res.index = slot[dpx_pkg::IDX_OUT_W-1:0];
		end else if (fill_level >= ENTRIES) begin
			// full table: unknown color goes to index 0, flagged
			res.index    = '0;
			res.overflow = 1'b1;
			overflows++;
		end else begin
			palette_mirror[fill_level] = c;
			res.index  = fill_level[dpx_pkg::IDX_OUT_W-1:0];
			res.is_new = 1'b1;
			fill_level++;
			new_colors++;
		end
		// column-major address, wraps at the address width
		addr     = 32'(px_col) * 32'(height_mirror) + 32'(px_row);
		res.addr = addr[ADDR_W-1:0];
		return res;
	endfunction

	task automatic note_failure(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	// Per edge: retire a result beat, then apply a config beat, then predict a pixel beat.
	always @(posedge clk) begin : watch
		pixel_result_t want;
		pixel_result_t got;
		if (!arst_n) begin
			fill_level      = 0;
			height_mirror   = 1;
			expected_q.delete();
			mismatches      = 0;
			results_checked = 0;
			new_colors      = 0;
			overflows       = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{palette_index, new_entry, palette_overflow, store_address};
				if (expected_q.size() == 0) begin
					note_failure($sformatf("result with nothing expected: idx=%0d new=%0b ovf=%0b addr=%0d",
						got.index, got.is_new, got.overflow, got.addr));
				end else begin
					want = expected_q.pop_front();
					results_checked++;
					if (got !== want)
						note_failure($sformatf({"idx exp %0d got %0d, new exp %0b got %0b, ",
							"ovf exp %0b got %0b, addr exp %0d got %0d"},
							want.index, got.index, want.is_new, got.is_new,
							want.overflow, got.overflow, want.addr, got.addr));
				end
			end
			if (cfg_valid && cfg_ready)
				height_mirror = cfg_data;
			if (in_valid && in_ready)
				expected_q.push_back(index_pixel({blue, green, red}, column, row));
		end
		pending = expected_q.size();
	end

endmodule

>>> tb/dynamic_palette_indexer_tb.sv
// Top of the palette indexer testbench: clock, reset, pixel and config stimulus, verdict.
`timescale 1ns / 1ps

module dynamic_palette_indexer_tb;

	localparam int DIM_W        = 12;
	localparam int ADDR_W       = 24;
	localparam int RANDOM_ITEMS = 1100;
	localparam int PHASES       = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int LIMIT        = 400000;
	localparam logic [DIM_W-1:0] COORD_MAX = '1;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [DIM_W:0]                  cfg_data;
	logic                            in_valid;
	logic                            in_ready;
	logic [dpx_pkg::CH_W-1:0]        red;
	logic [dpx_pkg::CH_W-1:0]        green;
	logic [dpx_pkg::CH_W-1:0]        blue;
	logic [DIM_W-1:0]                column;
	logic [DIM_W-1:0]                row;
	logic                            out_valid;
	logic                            out_ready;
	logic [dpx_pkg::IDX_OUT_W-1:0]   palette_index;
	logic                            new_entry;
	logic                            palette_overflow;
	logic [ADDR_W-1:0]               store_address;

	int mismatches;
	int pending;
	int results_checked;
	int new_colors;
	int overflows;

	int unsigned cycle_count = 0;
	int          pixels_sent = 0;
	int          heights_set = 0;
	bit          tx_calm     = 1'b0;
	bit          rx_calm     = 1'b0;
	bit          hold_go     = 1'b0;
	bit          rx_hold     = 1'b0;
	int          rx_wait     = 0;

	dpx_pkg::color_t sent_colors [$];

	dynamic_palette_indexer #(
		.PALETTE_ENTRIES(256),
		.MAX_DIMENSION  (4096)
	) DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.red             (red),
		.green           (green),
		.blue            (blue),
		.column          (column),
		.row             (row),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.palette_index   (palette_index),
		.new_entry       (new_entry),
		.palette_overflow(palette_overflow),
		.store_address   (store_address)
	);

	dynamic_palette_indexer_checker #(
		.ENTRIES(256),
		.DIM_W  (DIM_W),
		.ADDR_W (ADDR_W)
	) scoreboard (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.red             (red),
		.green           (green),
		.blue            (blue),
		.column          (column),
		.row             (row),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.palette_index   (palette_index),
		.new_entry       (new_entry),
		.palette_overflow(palette_overflow),
		.store_address   (store_address),
		.mismatches      (mismatches),
		.pending         (pending),
		.results_checked (results_checked),
		.new_colors      (new_colors),
		.overflows       (overflows)
	);

	// clock, 8 ns period
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles, %0d results still outstanding", cycle_count, pending);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// idle gap before a beat: none in calm stretches, else often none, otherwise a random draw
	function automatic int draw_gap(input bit calm);
		if (calm || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	// fresh colors, single-bit neighbors of sent colors, and plain repeats
	function automatic dpx_pkg::color_t pick_color();
		dpx_pkg::color_t c;
		int              sel;
		sel = $urandom_range(0, 99);
		if (sent_colors.size() == 0 || sel < 25) begin
			c = dpx_pkg::color_t'($urandom);
			sent_colors.push_back(c);
		end else if (sel < 40) begin
			c = sent_colors[$urandom_range(0, sent_colors.size() - 1)]
				^ (dpx_pkg::color_t'(1) << $urandom_range(0, dpx_pkg::COLOR_W - 1));
			sent_colors.push_back(c);
		end else begin
			c = sent_colors[$urandom_range(0, sent_colors.size() - 1)];
		end
		return c;
	endfunction

	function automatic logic [DIM_W-1:0] pick_coord();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return COORD_MAX;
		return DIM_W'($urandom);
	endfunction

	// Offer one pixel beat; valid stays high from the previous beat when no gap is drawn.
	task automatic send_pixel(input dpx_pkg::color_t c, input logic [DIM_W-1:0] px_col,
			input logic [DIM_W-1:0] px_row);
		int gap;
		gap = draw_gap(tx_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		red      <= c[7:0];
		green    <= c[15:8];
		blue     <= c[23:16];
		column   <= px_col;
		row      <= px_row;
		do @(posedge clk); while (!in_ready);
		pixels_sent++;
	endtask

	// Stop offering and wait until every result is back, plus pipeline slack.
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_height(input logic [DIM_W:0] h);
		cfg_valid <= 1'b1;
		cfg_data  <= h;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		heights_set++;
	endtask

	// result side: random gap after each beat, forced low during the hold-off
	initial begin
		out_ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				rx_wait = draw_gap(rx_calm);
			if (rx_hold) begin
				out_ready <= 1'b0;
			end else if (rx_wait > 0) begin
				out_ready <= 1'b0;
				rx_wait--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// long receiver hold-off, timed on falling edges
	initial begin
		wait (hold_go);
		@(negedge clk);
		rx_hold = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		rx_hold = 1'b0;
	end

	// main stimulus
	initial begin : stimulus
		int             phase;
		logic [DIM_W:0] h;
		arst_n    = 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		red       <= '0;
		green     <= '0;
		blue      <= '0;
		column    <= '0;
		row       <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: height 1 from reset, color and coordinate extremes, hits and misses
		send_pixel(24'h000000, '0, '0);
		send_pixel(24'hFFFFFF, COORD_MAX, COORD_MAX);
		send_pixel(24'h000000, 12'd5, 12'd7);          // hit on first entry
		send_pixel(24'h0000FF, 12'd1, 12'd0);          // red only
		send_pixel(24'h00FF00, 12'd2, 12'd0);          // green only
		send_pixel(24'hFF0000, 12'd3, 12'd0);          // blue only
		send_pixel(24'hFFFFFF, 12'd0, COORD_MAX);      // hit on white
		send_pixel(24'h000001, 12'd0, 12'd1);          // one bit off black
		send_pixel(24'h7FFFFF, 12'd0, 12'd2);          // one bit off white
		wait_idle();
		// tallest image: far corner lands on the top address
		write_height(13'd4096);
		send_pixel(24'hFFFFFF, COORD_MAX, COORD_MAX);
		send_pixel(24'h0000FF, 12'd0, COORD_MAX);
		send_pixel(24'h563412, COORD_MAX, 12'd0);
		wait_idle();
		// largest register value: product wraps the address
		write_height(13'h1FFF);
		send_pixel(24'hAAAAAA, COORD_MAX, COORD_MAX);
		send_pixel(24'h555555, 12'd1, 12'd0);
		send_pixel(24'hAAAAAA, 12'h800, 12'h800);
		wait_idle();
		// zero height: address is the row alone
		write_height(13'd0);
		send_pixel(24'h555555, COORD_MAX, 12'd1234);
		send_pixel(24'h00FF00, 12'h555, COORD_MAX);
		send_pixel(24'h123456, 12'hAAA, 12'h555);

		// random phases: palette fills, then hits and overflows mix
		for (phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			case (phase)
				0:       h = 13'($urandom_range(1, 4096));
				1:       h = 13'h1FFF;
				2:       h = 13'd4096;
				3:       h = 13'd0;
				4:       h = 13'd1;
				5:       h = 13'($urandom_range(1, 4096));
				6:       h = 13'($urandom_range(0, 8191));
				default: h = 13'($urandom_range(2, 640));
			endcase
			tx_calm = (phase == 2) || (phase == 5);
			rx_calm = (phase == 5);
			write_height(h);
			// back-to-back pixels against a stalled output fill the pipeline
			if (phase == 2)
				hold_go = 1'b1;
			repeat (RANDOM_ITEMS / PHASES) send_pixel(pick_color(), pick_coord(), pick_coord());
		end
		wait_idle();

		$display("Sent %0d pixels over %0d height writes; %0d results compared, %0d new colors, %0d overflows",
			pixels_sent, heights_set, results_checked, new_colors, overflows);
		if (mismatches == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
